### src/ept_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_pkg
// Shared types, constants and helpers for the encoder position and speed
// tracker: controller states, command bundle, register indexes, scale factors.
// ----------------------------------------------------------------------------
package ept_pkg;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNTS_PER_REV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNTER_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WRAP_THRESHOLD = 2'd2;

	localparam logic [15:0] RST_COUNTS_PER_REV = 16'd4096;
	localparam logic [14:0] RST_COUNTER_LIMIT  = 15'd32000;
	localparam logic [14:0] RST_WRAP_THRESHOLD = 15'd20000;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// fixed field widths
	localparam int POS_W   = 64;
	localparam int STEP_W  = 16;
	localparam int SPEED_W = 32;
	localparam int ANGLE_W = 17;
	localparam int CPR_W   = 16;

	// speed divider: quotient bits 33..0, bit 33 only flags overflow
	localparam int SPD_QUOT_W = 34;
	localparam int SPD_CNT_W  = $clog2(SPD_QUOT_W);

	// angle: remainder pass digit by digit, then a short restoring divide
	localparam int ANG_DIGIT_W   = 4;
	localparam int ANG_MOD_STEPS = POS_W / ANG_DIGIT_W;
	localparam int ANG_Q_W       = 16;
	localparam int ANG_PROD_W    = CPR_W + ANG_Q_W;

	// scale factors
	localparam logic [19:0] SEC_SCALE = 20'd1000000;
	localparam logic [25:0] MIN_SCALE = 26'd60000000;
	localparam logic [15:0] ANG_FULL  = 16'd36000;
	localparam int          SEC_SCALE_W = 20;
	localparam int          MIN_SCALE_W = 26;
	localparam int          Q16_SHIFT   = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} ept_state_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic mul;
		logic load;
		logic div;
		logic ang_mod;
		logic ang_mul;
		logic ang_div;
		logic finish;
	} ept_cmd_t;

	// clamp an unsigned quotient to the signed 32-bit range and apply the sign
	function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPD_QUOT_W-1:0] q,
		input logic neg);
		logic [SPD_QUOT_W-1:0] lim;
		logic [SPD_QUOT_W-1:0] v;
		lim = neg ? SPD_QUOT_W'(34'h0_8000_0000) : SPD_QUOT_W'(34'h0_7FFF_FFFF);
		v = (q > lim) ? lim : q;
		return neg ? (SPEED_W'(0) - v[SPEED_W-1:0]) : v[SPEED_W-1:0];
	endfunction

endpackage

### src/ept_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_in_if
// Sample channel: valid/ready handshake with request type, counter value and
// microsecond timestamp.
// ----------------------------------------------------------------------------
interface ept_in_if #(
	parameter int COUNTER_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic signed [COUNTER_WIDTH-1:0] counter_value;
	logic [63:0]                     time_us;

	modport source (output valid, req_type, counter_value, time_us, input ready);
	modport sink (input valid, req_type, counter_value, time_us, output ready);
endinterface

### src/ept_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_out_if
// Result channel: valid/ready handshake with step, position, elapsed time,
// speeds and angle.
// ----------------------------------------------------------------------------
interface ept_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] step_delta;
	logic signed [63:0] position;
	logic [63:0]        elapsed_us;
	logic signed [31:0] revs_per_sec_q16;
	logic signed [31:0] revs_per_min;
	logic signed [16:0] angle_centideg;

	modport source (output valid, step_delta, position, elapsed_us, revs_per_sec_q16,
		revs_per_min, angle_centideg, input ready);
	modport sink (input valid, step_delta, position, elapsed_us, revs_per_sec_q16,
		revs_per_min, angle_centideg, output ready);
endinterface

### src/ept_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_ctrl
// Controller: sequences capture, multiply, divider steps and result hand-off,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module ept_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_clear,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output ept_pkg::ept_cmd_t cmd
);

	ept_pkg::ept_state_t              state_q;
	ept_pkg::ept_state_t              state_d;
	logic [ept_pkg::SPD_CNT_W-1:0]    cnt_q;
	logic                             out_valid_q;
	logic                             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ept_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.div) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result beat pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ept_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (in_clear == ept_pkg::REQ_CLEAR) ? ept_pkg::ST_DONE
						: ept_pkg::ST_PREP;
				end
			end
			ept_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ept_pkg::ST_MUL;
			end
			ept_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ept_pkg::ST_LOAD;
			end
			ept_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ept_pkg::ST_DIV;
			end
			ept_pkg::ST_DIV: begin
				cmd.div     = 1'b1;
				cmd.ang_mod = (cnt_q < ept_pkg::SPD_CNT_W'(ept_pkg::ANG_MOD_STEPS));
				cmd.ang_mul = (cnt_q == ept_pkg::SPD_CNT_W'(ept_pkg::ANG_MOD_STEPS));
				cmd.ang_div = (cnt_q > ept_pkg::SPD_CNT_W'(ept_pkg::ANG_MOD_STEPS)) &&
					(cnt_q <= ept_pkg::SPD_CNT_W'(ept_pkg::ANG_MOD_STEPS + ept_pkg::ANG_Q_W));
				if (cnt_q == ept_pkg::SPD_CNT_W'(ept_pkg::SPD_QUOT_W - 1)) begin
					state_d = ept_pkg::ST_DONE;
				end
			end
			ept_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ept_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ept_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/ept_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_dp
// Datapath: configuration registers, wrap correction, position and time state,
// two-lane restoring speed divider, angle remainder/divide unit, result regs.
// ----------------------------------------------------------------------------
module ept_dp #(
	parameter int COUNTER_WIDTH = 16,
	parameter int TIME_WIDTH    = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ept_pkg::ept_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                req_type,
	input  logic signed [COUNTER_WIDTH-1:0]     counter_value,
	input  logic [63:0]                         time_us,
	output logic signed [ept_pkg::STEP_W-1:0]   step_delta,
	output logic signed [ept_pkg::POS_W-1:0]    position,
	output logic [63:0]                         elapsed_us,
	output logic signed [ept_pkg::SPEED_W-1:0]  revs_per_sec_q16,
	output logic signed [ept_pkg::SPEED_W-1:0]  revs_per_min,
	output logic signed [ept_pkg::ANGLE_W-1:0]  angle_centideg
);

	// corrected difference width: room for counter span plus the limit
	localparam int DW   = ((COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16) + 2;
	localparam int MW   = DW;
	localparam int NPW  = MW + ept_pkg::SEC_SCALE_W;
	localparam int NSW  = NPW + ept_pkg::Q16_SHIFT;
	localparam int NRW  = MW + ept_pkg::MIN_SCALE_W;
	localparam int DENW = ept_pkg::CPR_W + TIME_WIDTH;
	localparam int DSW  = DENW + ept_pkg::SPD_QUOT_W - 1;
	localparam int PPW  = ept_pkg::CPR_W + 32;
	localparam int ADSW = ept_pkg::CPR_W + ept_pkg::ANG_Q_W - 1;

	// configuration
	logic [15:0] cpr_q;
	logic [14:0] limit_q;
	logic [14:0] thr_q;

	// architectural state
	logic signed [COUNTER_WIDTH-1:0] prev_cnt_q;
	logic [TIME_WIDTH-1:0]           prev_time_q;
	logic [ept_pkg::POS_W-1:0]       pos_q;

	// per-item working registers
	logic                            clr_q;
	logic signed [DW-1:0]            diff_q;
	logic [TIME_WIDTH-1:0]           el_q;
	logic                            neg_q;
	logic [MW-1:0]                   mag_q;
	logic [PPW-1:0]                  plo_q;
	logic [PPW-1:0]                  phi_q;
	logic [NPW-1:0]                  ns_q;
	logic [NRW-1:0]                  nr_q;
	logic [DENW-1:0]                 den_q;
	logic                            spd_zero_q;
	logic [DSW-1:0]                  ds_q;
	logic [NSW-1:0]                  rs_q;
	logic [NRW-1:0]                  rr_q;
	logic [ept_pkg::SPD_QUOT_W-1:0]  qs_q;
	logic [ept_pkg::SPD_QUOT_W-1:0]  qr_q;
	logic                            pneg_q;
	logic [ept_pkg::POS_W-1:0]       pm_q;
	logic [ept_pkg::CPR_W-1:0]       arem_q;
	logic [ept_pkg::ANG_PROD_W-1:0]  aprod_q;
	logic [ADSW-1:0]                 ads_q;
	logic [ept_pkg::ANG_Q_W-1:0]     aq_q;

	// combinational helpers
	logic signed [DW-1:0]            cur_x;
	logic signed [DW-1:0]            prev_x;
	logic signed [DW-1:0]            thr_x;
	logic signed [DW-1:0]            lim_x;
	logic signed [DW-1:0]            raw_diff;
	logic signed [DW-1:0]            cor_diff;
	logic [TIME_WIDTH-1:0]           tm;
	logic [63:0]                     el64;
	logic                            s_take;
	logic                            r_take;
	logic                            a_take;
	logic [ept_pkg::CPR_W-1:0]       arem_d;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q   <= ept_pkg::RST_COUNTS_PER_REV;
			limit_q <= ept_pkg::RST_COUNTER_LIMIT;
			thr_q   <= ept_pkg::RST_WRAP_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ept_pkg::CFG_IDX_COUNTS_PER_REV: cpr_q   <= cfg_wdata[15:0];
				ept_pkg::CFG_IDX_COUNTER_LIMIT:  limit_q <= cfg_wdata[14:0];
				ept_pkg::CFG_IDX_WRAP_THRESHOLD: thr_q   <= cfg_wdata[14:0];
				default: begin
				end
			endcase
		end
	end

	// wrap-corrected difference
	always_comb begin
		cur_x    = DW'(counter_value);
		prev_x   = DW'(prev_cnt_q);
		thr_x    = DW'(signed'({1'b0, thr_q}));
		lim_x    = DW'(signed'({1'b0, limit_q}));
		raw_diff = cur_x - prev_x;
		if (raw_diff > thr_x) begin
			cor_diff = raw_diff - lim_x;
		end else if (raw_diff < -thr_x) begin
			cor_diff = raw_diff + lim_x;
		end else begin
			cor_diff = raw_diff;
		end
		tm   = time_us[TIME_WIDTH-1:0];
		el64 = 64'(el_q);
	end

	// position, previous count and previous time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cnt_q  <= '0;
			prev_time_q <= '0;
			pos_q       <= '0;
			clr_q       <= 1'b0;
		end else if (cmd.capture) begin
			if (req_type == ept_pkg::REQ_CLEAR) begin
				prev_cnt_q <= '0;
				pos_q      <= '0;
				clr_q      <= 1'b1;
			end else begin
				prev_cnt_q  <= counter_value;
				prev_time_q <= tm;
				clr_q       <= 1'b0;
			end
		end else if (cmd.prep) begin
			pos_q <= pos_q + ept_pkg::POS_W'(diff_q);
		end
	end

	// capture, magnitude and partial products of the time base
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			diff_q <= cor_diff;
			el_q   <= tm - prev_time_q;
		end
		if (cmd.prep) begin
			neg_q <= diff_q[DW-1];
			mag_q <= diff_q[DW-1] ? MW'(-diff_q) : MW'(diff_q);
			plo_q <= PPW'(cpr_q) * PPW'(el64[31:0]);
			phi_q <= PPW'(cpr_q) * PPW'(el64[63:32]);
		end
	end

	// scaled numerators, denominator, absolute position shifted out by the remainder pass
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			ns_q   <= NPW'(mag_q) * NPW'(ept_pkg::SEC_SCALE);
			nr_q   <= NRW'(mag_q) * NRW'(ept_pkg::MIN_SCALE);
			den_q  <= DENW'({phi_q, 32'd0} + (PPW + 32)'(plo_q));
			pneg_q <= pos_q[ept_pkg::POS_W-1];
			pm_q   <= pos_q[ept_pkg::POS_W-1] ? (ept_pkg::POS_W'(0) - pos_q) : pos_q;
		end else if (cmd.div && cmd.ang_mod) begin
			pm_q <= pm_q << ept_pkg::ANG_DIGIT_W;
		end
	end

	// divider step decisions
	always_comb begin
		s_take = (ds_q[DSW-1:NSW] == '0) && (ds_q[NSW-1:0] <= rs_q);
		r_take = (ds_q[DSW-1:NRW] == '0) && (ds_q[NRW-1:0] <= rr_q);
		a_take = ({1'b0, ads_q} <= aprod_q);
	end

	// angle remainder, a few bits of position per cycle
	always_comb begin
		logic [ept_pkg::CPR_W:0]   t;
		logic [ept_pkg::POS_W-1:0] p;
		logic [ept_pkg::CPR_W-1:0] r;
		r = arem_q;
		p = pm_q;
		for (int k = 0; k < ept_pkg::ANG_DIGIT_W; k++) begin
			t = {r, p[ept_pkg::POS_W-1]};
			p = p << 1;
			if (t >= {1'b0, cpr_q}) begin
				t = t - {1'b0, cpr_q};
			end
			r = t[ept_pkg::CPR_W-1:0];
		end
		arem_d = r;
	end

	// speed lanes and angle unit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rs_q       <= {ns_q, ept_pkg::Q16_SHIFT'(0)};
			rr_q       <= nr_q;
			ds_q       <= {den_q, (ept_pkg::SPD_QUOT_W - 1)'(0)};
			spd_zero_q <= (den_q == '0);
			qs_q       <= '0;
			qr_q       <= '0;
			arem_q     <= '0;
		end else if (cmd.div) begin
			ds_q <= ds_q >> 1;
			qs_q <= {qs_q[ept_pkg::SPD_QUOT_W-2:0], s_take};
			qr_q <= {qr_q[ept_pkg::SPD_QUOT_W-2:0], r_take};
			if (s_take) begin
				rs_q <= rs_q - ds_q[NSW-1:0];
			end
			if (r_take) begin
				rr_q <= rr_q - ds_q[NRW-1:0];
			end
			if (cmd.ang_mod) begin
				arem_q <= arem_d;
			end
			if (cmd.ang_mul) begin
				aprod_q <= ept_pkg::ANG_PROD_W'(arem_q) * ept_pkg::ANG_PROD_W'(ept_pkg::ANG_FULL);
				ads_q   <= {cpr_q, (ept_pkg::ANG_Q_W - 1)'(0)};
				aq_q    <= '0;
			end
			if (cmd.ang_div) begin
				ads_q <= ads_q >> 1;
				aq_q  <= {aq_q[ept_pkg::ANG_Q_W-2:0], a_take};
				if (a_take) begin
					aprod_q <= aprod_q - {1'b0, ads_q};
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (clr_q) begin
				step_delta       <= '0;
				position         <= '0;
				elapsed_us       <= '0;
				revs_per_sec_q16 <= '0;
				revs_per_min     <= '0;
				angle_centideg   <= '0;
			end else begin
				step_delta <= diff_q[ept_pkg::STEP_W-1:0];
				position   <= pos_q;
				elapsed_us <= 64'(el_q);
				revs_per_sec_q16 <= spd_zero_q ? '0 : ept_pkg::sat_speed(qs_q, neg_q);
				revs_per_min     <= spd_zero_q ? '0 : ept_pkg::sat_speed(qr_q, neg_q);
				if (cpr_q == '0) begin
					angle_centideg <= '0;
				end else if (pneg_q) begin
					angle_centideg <= ept_pkg::ANGLE_W'(0) - ept_pkg::ANGLE_W'(aq_q);
				end else begin
					angle_centideg <= ept_pkg::ANGLE_W'(aq_q);
				end
			end
		end
	end

endmodule

### src/encoder_position_speed_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_speed_tracker_unit
// Extends a wrapping pulse counter to a 64-bit position and reports step,
// elapsed time, speed in rev/s (Q16.16) and rpm, and angle in centidegrees.
//
//   channel  dir  beat contents
//   sample   in   req_type, counter_value, time_us
//   result   out  step_delta, position, elapsed_us, revs_per_sec_q16,
//                 revs_per_min, angle_centideg
//   cfg      in   cfg_we, cfg_index, cfg_wdata (write only)
//
// A sample beat passes from accept through the prep, multiply and load states
// and the 34 steps of the two-lane bit-serial speed divider to its result load;
// the angle unit runs alongside the divider. A clear beat goes from accept
// straight to its result load. The next beat is taken no earlier than the cycle
// after that load. The result register holds a finished beat while the next
// sample is taken; a stalled result only delays the load of the following one.
// Reset restores register defaults and zeroes state.
// ----------------------------------------------------------------------------
module encoder_position_speed_tracker_unit #(
	parameter int COUNTER_WIDTH = 16,
	parameter int TIME_WIDTH    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ept_in_if.sink                        sample,
	ept_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ept_pkg::CFG_W-1:0]     cfg_wdata
);

	ept_pkg::ept_cmd_t cmd;

	// sequencer and handshakes
	ept_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_clear  (sample.req_type),
		.out_ready (result.ready),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	// arithmetic and state
	ept_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.TIME_WIDTH    (TIME_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_type         (sample.req_type),
		.counter_value    (sample.counter_value),
		.time_us          (sample.time_us),
		.step_delta       (result.step_delta),
		.position         (result.position),
		.elapsed_us       (result.elapsed_us),
		.revs_per_sec_q16 (result.revs_per_sec_q16),
		.revs_per_min     (result.revs_per_min),
		.angle_centideg   (result.angle_centideg)
	);

endmodule

### bench/tb_encoder_position_speed_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_position_speed_tracker_unit
// Self-checking bench for the encoder position and speed tracker. A directed
// table covers reset state, counter wraps, timestamp wrap, speed saturation
// and clear requests; random counter trajectories follow under several
// register settings and handshake idle patterns. Every result beat is checked
// against a cycle-free model of the tracker kept in the bench.
// ----------------------------------------------------------------------------
module tb_encoder_position_speed_tracker_unit;

	localparam int                            PHASES      = 8;
	localparam int                            PHASE_BEATS = 80;
	localparam int                            SETTLE      = 50;
	localparam int                            WD_LIMIT    = 4000;
	localparam int                            MAX_SHOWN   = 10;
	localparam logic [ept_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

	typedef struct packed {
		logic signed [15:0] step;
		logic signed [63:0] pos;
		logic [63:0]        elapsed;
		logic signed [31:0] rps;
		logic signed [31:0] rpm;
		logic signed [16:0] angle;
	} motion_report_t;

	typedef struct packed {
		logic           req;
		logic [15:0]    count;
		logic [63:0]    stamp;
		logic           typed;
		motion_report_t want;
	} stim_row_t;

	localparam motion_report_t NO_MOTION = '0;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [ept_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ept_pkg::CFG_W-1:0] cfg_wdata;

	ept_in_if  sample_bus ();
	ept_out_if result_bus ();

	encoder_position_speed_tracker_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_bus),
		.result    (result_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// tracker model state and its copy of the registers
	logic [15:0]        cpr_set;
	logic [14:0]        limit_set;
	logic [14:0]        thresh_set;
	logic signed [15:0] prior_count;
	logic [63:0]        last_stamp;
	logic [63:0]        position_acc;

	motion_report_t motion_q[$];
	stim_row_t      plan[$];
	motion_report_t seen;
	motion_report_t want;

	int in_idle_pct;
	int out_idle_pct;
	int fail_count;
	int checked;
	int sample_beats;
	int clear_beats;
	int settings_used;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clamp a speed magnitude to the signed 32-bit range and apply the sign
	function automatic logic [31:0] clamp_speed(input logic [63:0] mag, input logic neg);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (mag > lim)
			mag = lim;
		return neg ? 32'(64'd0 - mag) : mag[31:0];
	endfunction

	// advance the tracker by one request and return its report
	function automatic motion_report_t track_motion(input logic req, input logic [15:0] count,
		input logic [63:0] stamp);
		motion_report_t r;
		longint         diff;
		logic [63:0]    mag;
		logic [63:0]    pmag;
		logic [63:0]    ang;
		logic           neg;
		logic           pneg;
		r = '0;
		if (req == ept_pkg::REQ_CLEAR) begin
			position_acc = '0;
			prior_count = '0;
			return r;
		end
		diff = longint'($signed(count)) - longint'(prior_count);
		if (diff > longint'(thresh_set))
			diff -= longint'(limit_set);
		else if (diff < -longint'(thresh_set))
			diff += longint'(limit_set);
		prior_count = count;
		r.elapsed = stamp - last_stamp;
		last_stamp = stamp;
		position_acc = position_acc + 64'(diff);
		r.step = diff[15:0];
		r.pos = position_acc;

		// speeds: zero without elapsed time, without scale or without motion
		neg = diff < 0;
		mag = neg ? 64'(-diff) : 64'(diff);
		if (r.elapsed != 0 && cpr_set != 0 && mag != 0) begin
			r.rps = clamp_speed(((mag * 64'd1000000) << 16) / 64'(cpr_set) / r.elapsed, neg);
			r.rpm = clamp_speed((mag * 64'd60000000) / 64'(cpr_set) / r.elapsed, neg);
		end

		// angle within one revolution, sign follows position
		if (cpr_set != 0) begin
			pneg = position_acc[63];
			pmag = pneg ? (64'd0 - position_acc) : position_acc;
			ang = ((pmag % 64'(cpr_set)) * 64'd36000) / 64'(cpr_set);
			r.angle = pneg ? 17'(64'd0 - ang) : ang[16:0];
		end
		return r;
	endfunction

	// offer one sample beat, wait for acceptance, then record its expectation
	task automatic drive_item(input logic req, input logic [15:0] count, input logic [63:0] stamp,
		input logic typed, input motion_report_t typed_want);
		motion_report_t predicted;
		logic           taken;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.req_type <= req;
		sample_bus.counter_value <= count;
		sample_bus.time_us <= stamp;
		// ready is settled mid-cycle, so it tells whether the coming edge takes the beat
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = sample_bus.ready;
			@(posedge clk);
		end
		predicted = track_motion(req, count, stamp);
		motion_q.push_back(typed ? typed_want : predicted);
		if (req == ept_pkg::REQ_CLEAR)
			clear_beats++;
		else
			sample_beats++;
	endtask

	// write all registers back to back, the spare index first
	task automatic program_regs(input logic [15:0] cpr, input logic [14:0] lim,
		input logic [14:0] thr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_SPARE;
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_index <= ept_pkg::CFG_IDX_COUNTS_PER_REV;
		cfg_wdata <= cpr;
		@(posedge clk);
		cfg_index <= ept_pkg::CFG_IDX_COUNTER_LIMIT;
		cfg_wdata <= {1'b0, lim};
		@(posedge clk);
		cfg_index <= ept_pkg::CFG_IDX_WRAP_THRESHOLD;
		cfg_wdata <= {1'b0, thr};
		@(posedge clk);
		cfg_we <= 1'b0;
		cpr_set = cpr;
		limit_set = lim;
		thresh_set = thr;
		settings_used++;
	endtask

	// result checker, sampled mid-cycle where the handshake is settled for the next edge
	always @(negedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			seen = '{result_bus.step_delta, result_bus.position, result_bus.elapsed_us,
				result_bus.revs_per_sec_q16, result_bus.revs_per_min,
				result_bus.angle_centideg};
			if (motion_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t: result beat with nothing expected", $realtime);
			end else begin
				want = motion_q.pop_front();
				if (seen.step !== want.step || seen.pos !== want.pos ||
					seen.elapsed !== want.elapsed || seen.rps !== want.rps ||
					seen.rpm !== want.rpm || seen.angle !== want.angle) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("%0t: result %0d mismatch", $realtime, checked);
						$display("  exp step=%0d pos=%0d el=%0d rps=%0d rpm=%0d ang=%0d",
							want.step, want.pos, want.elapsed, want.rps, want.rpm,
							want.angle);
						$display("  got step=%0d pos=%0d el=%0d rps=%0d rpm=%0d ang=%0d",
							seen.step, seen.pos, seen.elapsed, seen.rps, seen.rpm,
							seen.angle);
					end
				end
				checked++;
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (arst_n)
			result_bus.ready <= ($urandom_range(0, 99) >= out_idle_pct);
	end

	// watchdog on cycles without any beat
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WD_LIMIT) begin
			@(negedge clk);
			if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles, %0d results pending", WD_LIMIT,
			motion_q.size());
		$display("tb_encoder_position_speed_tracker_unit: FAIL");
		$finish;
	end

	// stimulus
	initial begin
		int          pick;
		int          step;
		int          span;
		int          wrap_mod;
		int          gen_count;
		logic [63:0] gen_stamp;
		logic        req;
		logic [15:0] count;
		logic [63:0] stamp;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.req_type = ept_pkg::REQ_SAMPLE;
		sample_bus.counter_value = '0;
		sample_bus.time_us = '0;
		result_bus.ready = 1'b0;
		fail_count = 0;
		checked = 0;
		sample_beats = 0;
		clear_beats = 0;
		settings_used = 0;
		in_idle_pct = 27;
		out_idle_pct = 54;
		cpr_set = ept_pkg::RST_COUNTS_PER_REV;
		limit_set = ept_pkg::RST_COUNTER_LIMIT;
		thresh_set = ept_pkg::RST_WRAP_THRESHOLD;
		prior_count = '0;
		last_stamp = '0;
		position_acc = '0;
		gen_count = 0;
		gen_stamp = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset register values
		// all-zero report right after reset
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'd0, 64'd0, 1'b1, NO_MOTION});
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'd100, 64'd1000, 1'b0, NO_MOTION});
		// forward jump past the threshold reads as a counter wrap
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h7FFF, 64'd1001, 1'b0, NO_MOTION});
		// backward jump, corrected step outside 16 bits, no time elapsed
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h8000, 64'd1001, 1'b0, NO_MOTION});
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h8000, 64'd1002, 1'b0, NO_MOTION});
		// clear ignores its payload and reports zeros
		plan.push_back('{ept_pkg::REQ_CLEAR, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			NO_MOTION});
		// timestamp is kept across a clear
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'd0, 64'd1002, 1'b1, NO_MOTION});
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'hFFFB, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0,
			NO_MOTION});
		// timestamp wraps through zero
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'hFFFB, 64'd5, 1'b0, NO_MOTION});
		// one microsecond with large steps: both speed limits
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'd30000, 64'd6, 1'b0, NO_MOTION});
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h7FFF, 64'd7, 1'b0, NO_MOTION});
		// elapsed time near its maximum
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h8001, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
			NO_MOTION});
		plan.push_back('{ept_pkg::REQ_SAMPLE, 16'h8001, 64'd0, 1'b0, NO_MOTION});
		plan.push_back('{ept_pkg::REQ_CLEAR, 16'd0, 64'd0, 1'b1, NO_MOTION});
		foreach (plan[i])
			drive_item(plan[i].req, plan[i].count, plan[i].stamp, plan[i].typed, plan[i].want);

		// random trajectories, one register setting per phase
		for (int phase = 0; phase < PHASES; phase++) begin
			sample_bus.valid <= 1'b0;
			while (motion_q.size() != 0)
				@(posedge clk);
			repeat (SETTLE) @(posedge clk);

			if (phase < 3) begin
				in_idle_pct = 27;
				out_idle_pct = 54;
			end else if (phase < 6) begin
				in_idle_pct = 54;
				out_idle_pct = 27;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end

			unique case (phase)
				0: program_regs(16'd4096, 15'd32000, 15'd20000);
				1: program_regs(16'd1, 15'd1, 15'd1);
				2: program_regs(16'd65535, 15'd32767, 15'd32767);
				// zero scale: speeds and angle read zero
				3: program_regs(16'd0, 15'd16384, 15'd8000);
				5: program_regs(16'd360, 15'd10000, 15'd5000);
				7: program_regs(16'd2000, 15'd32767, 15'd1);
				default: program_regs(16'($urandom_range(1, 65535)),
					15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)));
			endcase
			wrap_mod = (limit_set > 100) ? int'(limit_set) : 32767;

			for (int n = 0; n < PHASE_BEATS; n++) begin
				pick = $urandom_range(0, 99);
				req = ept_pkg::REQ_SAMPLE;
				if (pick < 7) begin
					// clear, payload is noise
					req = ept_pkg::REQ_CLEAR;
					count = 16'($urandom);
					stamp = {$urandom, $urandom};
					if ($urandom_range(0, 2) != 0)
						gen_count = 0;
				end else if (pick < 17) begin
					// arbitrary counter and timestamp
					count = 16'($urandom);
					stamp = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : gen_stamp;
					gen_count = int'($signed(count));
					gen_stamp = stamp;
				end else begin
					// counter moving and wrapping at the limit
					if (pick < 25) begin
						step = int'($urandom_range(0, 65534)) - 32767;
					end else begin
						span = ($urandom_range(0, 3) == 0) ? 3000 : 200;
						step = int'($urandom_range(0, 2 * span)) - span;
					end
					gen_count = (gen_count + step) % wrap_mod;
					pick = $urandom_range(0, 99);
					if (pick < 5)
						stamp = gen_stamp;
					else if (pick < 8)
						stamp = {$urandom, $urandom};
					else if (pick < 12)
						stamp = gen_stamp + 64'd1;
					else
						stamp = gen_stamp + 64'($urandom_range(1, 5000));
					count = 16'(gen_count);
					gen_stamp = stamp;
				end
				drive_item(req, count, stamp, 1'b0, NO_MOTION);
			end
		end

		// drain
		sample_bus.valid <= 1'b0;
		while (motion_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d samples and %0d clears over %0d register settings",
			sample_beats, clear_beats, settings_used);
		$display("%0d result beats compared, %0d failures", checked, fail_count);
		if (fail_count == 0)
			$display("tb_encoder_position_speed_tracker_unit: PASS");
		else
			$display("tb_encoder_position_speed_tracker_unit: FAIL");
		$finish;
	end

endmodule

### files.f
src/ept_pkg.sv
src/ept_in_if.sv
src/ept_out_if.sv
src/ept_ctrl.sv
src/ept_dp.sv
src/encoder_position_speed_tracker_unit.sv
bench/tb_encoder_position_speed_tracker_unit.sv
